/* src/first_fit_bin_allocator_unit_assert.svh */
// assertion macros for the first-fit bin allocator
`ifndef FIRST_FIT_BIN_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BIN_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// checks prop at every clock edge outside reset
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checks that cond holds in the cycle after trig
`define FFBA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`else

`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

/* src/ffba_pkg.sv */
// shared constants and control types of the first-fit bin allocator
package ffba_pkg;

  localparam int NUM_STACKS = 16;
  localparam int BIN_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CNT_W      = $clog2(NUM_STACKS + 1);

  localparam int FIELD_W     = 16;
  localparam int IDX_OUT_W   = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int OUT_TDATA_W = ((FIELD_W + IDX_OUT_W + 7) / 8) * 8;

  localparam logic [FIELD_W-1:0] CAP_RESET = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_OPEN_BIN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW_BIN    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERWEIGHT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALL_OPEN   = 2'd3;

  typedef struct packed {
    logic                load;     // latch the accepted word, restart the scan
    logic                rd;       // read the load at the scan pointer
    logic                wr_hit;   // add the weight to the bin under check
    logic                wr_open;  // open the next bin with the weight
    logic                res_set;  // capture the result code
    logic [STATUS_W-1:0] res_code;
    logic                out_load; // move the result into the output register
  } ffba_cmd_t;

  typedef struct packed {
    logic over;     // weight above capacity
    logic empty;    // no bin open yet
    logic full;     // every bin open
    logic rd_more;  // scan pointer still below the open count
    logic chk_v;    // read data valid for the bin under check
    logic fit;      // bin under check takes the weight
    logic last;     // bin under check is the last open bin
    logic out_free; // output register can take a word
  } ffba_stat_t;

endpackage

/* src/ffba_ctrl.sv */
// sequencing state machine of the first-fit bin allocator
module ffba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ffba_pkg::ffba_stat_t st,
  output ffba_pkg::ffba_cmd_t  cmd
);
  import ffba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = ST_OPEN_BIN;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.over) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OVERWEIGHT;
          state_nxt    = S_DONE;
        end else if (st.empty) begin
          cmd.wr_open  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NEW_BIN;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads run one bin ahead of the check
        cmd.rd = st.rd_more;
        if (st.chk_v && st.fit) begin
          cmd.wr_hit   = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OPEN_BIN;
          state_nxt    = S_DONE;
        end else if (st.chk_v && st.last) begin
          cmd.res_set = 1'b1;
          if (st.full) begin
            cmd.res_code = ST_ALL_OPEN;
          end else begin
            cmd.wr_open  = 1'b1;
            cmd.res_code = ST_NEW_BIN;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/ffba_datapath.sv */
// bin load memory, scan pointers, fit compare and output register
module ffba_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ffba_pkg::FIELD_W-1:0]     cfg_wr_data,
  input  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  ffba_pkg::ffba_cmd_t              cmd,
  output ffba_pkg::ffba_stat_t             st,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [ffba_pkg::STATUS_W-1:0]    out_tuser
);
  import ffba_pkg::*;

  logic [FIELD_W-1:0]   cap_r;
  logic [FIELD_W-1:0]   tag_r;
  logic [FIELD_W-1:0]   weight_r;
  logic [CNT_W-1:0]     open_r;
  logic [CNT_W-1:0]     rd_idx_r;
  logic [BIN_W-1:0]     chk_idx_r;
  logic                 chk_v_r;
  logic [FIELD_W-1:0]   rdata_r;
  logic [BIN_W-1:0]     res_idx_r;
  logic [STATUS_W-1:0]  res_st_r;
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_tag_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [STATUS_W-1:0]  out_st_r;

  logic [FIELD_W-1:0] load_mem [NUM_STACKS];

  logic [FIELD_W:0]           sum;
  logic [BIN_W-1:0]           open_idx;
  logic [BIN_W-1:0]           wr_addr;
  logic [FIELD_W-1:0]         wr_data;
  logic [BIN_W+IDX_OUT_W-1:0] idx_ext;

  assign sum      = {1'b0, rdata_r} + {1'b0, weight_r};
  assign open_idx = open_r[BIN_W-1:0];
  assign wr_addr  = cmd.wr_hit ? chk_idx_r : open_idx;
  assign wr_data  = cmd.wr_hit ? sum[FIELD_W-1:0] : weight_r;
  // result index is zero-extended here; the output register keeps its low bits
  assign idx_ext  = (BIN_W + IDX_OUT_W)'(res_idx_r);

  always_comb begin
    st.over     = (weight_r > cap_r);
    st.empty    = (open_r == '0);
    st.full     = (open_r == CNT_W'(NUM_STACKS));
    st.rd_more  = (rd_idx_r < open_r);
    st.chk_v    = chk_v_r;
    st.fit      = (sum <= {1'b0, cap_r});
    st.last     = ((CNT_W'(chk_idx_r) + CNT_W'(1)) == open_r);
    st.out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_hit || cmd.wr_open) begin
      load_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= load_mem[rd_idx_r[BIN_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      open_r      <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.wr_open) begin
        open_r <= open_r + CNT_W'(1);
      end
      chk_v_r <= cmd.rd && !cmd.load;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r    <= in_tdata[FIELD_W-1:0];
      weight_r <= in_tdata[2*FIELD_W-1:FIELD_W];
      rd_idx_r <= '0;
    end else if (cmd.rd) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
    if (cmd.rd) begin
      chk_idx_r <= rd_idx_r[BIN_W-1:0];
    end
    if (cmd.res_set) begin
      res_st_r <= cmd.res_code;
      if (cmd.wr_hit) begin
        res_idx_r <= chk_idx_r;
      end else if (cmd.wr_open) begin
        res_idx_r <= open_idx;
      end else begin
        res_idx_r <= '0;
      end
    end
    if (cmd.out_load) begin
      out_tag_r <= tag_r;
      out_idx_r <= idx_ext[IDX_OUT_W-1:0];
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_idx_r, out_tag_r});
  assign out_tuser  = out_st_r;

endmodule

/* src/first_fit_bin_allocator_unit.sv */
// first-fit bin allocator: top level with controller and datapath
// Online first-fit bin packing over NUM_STACKS bins.
// in channel: one word per item, tag and weight. out channel: one word per
// item, the echoed tag and the bin index, with the placement status in tuser.
// cfg_wr_en/cfg_wr_data set the bin capacity; write it only while idle.
// An accepted item is first compared against the capacity, then the open
// bins are scanned from bin 0 upward, one bin load read per cycle from the
// load memory, with the compare in the cycle after the read. The first bin
// that fits is updated; otherwise the next bin is opened if one is left.
// The next item is accepted the cycle after the result enters the output
// register, so while the receiver keeps up, the rate is set by the
// one-read-per-cycle scan.
// Reset (rst_n low, synchronous) closes all bins and sets capacity to
// 65535; no clearing pass is needed since only opened bins are read.
// A stalled receiver holds the word in the output register; one further
// item is taken and worked on, and the block then waits to hand it over.
module first_fit_bin_allocator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ffba_pkg::FIELD_W-1:0]     cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] item_tag, [31:16] item_weight
  input  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] result_tag, [19:16] bin_index, [23:20] zero
  output logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] place_status
  output logic [ffba_pkg::STATUS_W-1:0]    out_tuser
);
  import ffba_pkg::*;

  `include "first_fit_bin_allocator_unit_assert.svh"

  ffba_cmd_t  cmd;
  ffba_stat_t st;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ffba_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .st          (st),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  `FFBA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `FFBA_ASSERT(a_hit_checked, !cmd.wr_hit || (st.chk_v && st.fit), "bin update without fit")
  `FFBA_ASSERT(a_open_room, !cmd.wr_open || !st.full, "bin opened with all bins open")
  `FFBA_ASSERT(a_reject_idx, !(out_tvalid && (out_tuser == ST_OVERWEIGHT || out_tuser == ST_ALL_OPEN)) || (out_tdata[FIELD_W+IDX_OUT_W-1:FIELD_W] == '0), "unplaced item with nonzero bin")

endmodule

/* tb/ffba_placement_checker.sv */
`timescale 1ns / 100ps
// placement checker: predicts first-fit bin choices and compares each output word
module ffba_placement_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ffba_pkg::FIELD_W-1:0]     cfg_wr_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [ffba_pkg::STATUS_W-1:0]    out_tuser,
  output int                               fail_count,
  output int                               pending
);
  import ffba_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0]   tag;
    logic [IDX_OUT_W-1:0] bin;
    logic [STATUS_W-1:0]  status;
  } placement_t;

  logic [FIELD_W-1:0] capacity;
  logic [FIELD_W-1:0] bin_load [NUM_STACKS];
  int                 open_bins;
  placement_t         placement_q [$];

  // first-fit choice for one item, updating the bin loads
  function automatic placement_t first_fit_place(logic [FIELD_W-1:0] tag,
                                                 logic [FIELD_W-1:0] wt);
    placement_t r;
    logic [FIELD_W:0] sum;
    r.tag    = tag;
    r.bin    = '0;
    r.status = ST_ALL_OPEN;
    if (wt > capacity) begin
      r.status = ST_OVERWEIGHT;
      return r;
    end
    for (int k = 0; k < open_bins; k++) begin
      sum = {1'b0, bin_load[k]} + {1'b0, wt};
      if (sum <= {1'b0, capacity}) begin
        bin_load[k] = sum[FIELD_W-1:0];
        r.bin       = k[IDX_OUT_W-1:0];
        r.status    = ST_OPEN_BIN;
        return r;
      end
    end
    if (open_bins < NUM_STACKS) begin
      bin_load[open_bins] = wt;
      r.bin               = open_bins[IDX_OUT_W-1:0];
      r.status            = ST_NEW_BIN;
      open_bins++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    placement_t want, got, nxt;
    if (!rst_n) begin
      capacity  = CAP_RESET;
      open_bins = 0;
      for (int k = 0; k < NUM_STACKS; k++) bin_load[k] = '0;
      placement_q.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        nxt         = first_fit_place(in_tdata[FIELD_W-1:0],
                                      in_tdata[2*FIELD_W-1:FIELD_W]);
        placement_q = {placement_q, nxt};
      end
      if (out_tvalid && out_tready) begin
        got.tag    = out_tdata[FIELD_W-1:0];
        got.bin    = out_tdata[FIELD_W+IDX_OUT_W-1:FIELD_W];
        got.status = out_tuser;
        if (placement_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output word: tag %h bin %0d status %0d",
                     got.tag, got.bin, got.status);
          fail_count++;
        end else begin
          want = placement_q.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display({"mismatch: tag exp %h got %h, bin exp %0d got %0d, ",
                        "status exp %0d got %0d"},
                       want.tag, got.tag, want.bin, got.bin, want.status, got.status);
            fail_count++;
          end
        end
      end
    end
    pending = placement_q.size();
  end

endmodule

/* tb/tb_first_fit_bin_allocator_unit.sv */
`timescale 1ns / 100ps
// testbench top: drives items and capacity writes into the first-fit bin allocator
module tb_first_fit_bin_allocator_unit;
  import ffba_pkg::*;

  localparam int SETTLE_CYCLES = NUM_STACKS + 8;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [FIELD_W-1:0]     cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  int                     fail_count;
  int                     pending;

  int idle_pct  = 11;
  int stall_pct = 11;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_fit_bin_allocator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  ffba_placement_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #8000000;
    $display("first_fit_bin_allocator_unit verification failed");
    $finish;
  end

  task automatic send_item(input logic [FIELD_W-1:0] tag, input logic [FIELD_W-1:0] wt);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wt, tag};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and let every placement come out before touching capacity
  task automatic wait_all_placed();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [FIELD_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly light items so the bins keep room, with some near the capacity edge
  function automatic logic [FIELD_W-1:0] pick_weight(int cap);
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 50) return FIELD_W'($urandom_range(cap / 64));
    if (sel < 75) return FIELD_W'($urandom_range(cap / 8));
    if (sel < 85) return FIELD_W'($urandom_range(cap * 3 / 4, cap / 4));
    if (sel < 93) begin
      v = cap + int'($urandom_range(3)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return FIELD_W'(v);
    end
    return FIELD_W'($urandom());
  endfunction

  initial begin
    int phase_cap [9];
    int phase_len [9];
    int cap;

    phase_cap = '{300, 1000, 5000, 20000, 65535, -1, 0, 65535, 40000};
    phase_len = '{60, 60, 60, 70, 70, 60, 20, 70, 60};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: zero weights, exact fills
    send_item(16'h0000, 16'h0000);  // opens bin 0 with no load
    send_item(16'hFFFF, 16'h0000);
    send_item(16'hAAAA, 16'h0001);
    send_item(16'h5555, 16'hFFFF);  // too big for bin 0, opens bin 1
    send_item(16'h0001, 16'hFFFE);  // fills bin 0 exactly
    wait_all_placed();

    // capacity below every load: overweight, then skipped bins
    write_capacity(16'h0000);
    send_item(16'h1234, 16'h0001);
    send_item(16'h8000, 16'hFFFF);
    send_item(16'h7FFF, 16'h0000);
    send_item(16'h00FF, 16'h0000);
    wait_all_placed();

    // unit capacity: unit items fill bin 2, then each opens a bin until all are open
    write_capacity(16'h0001);
    for (int k = 0; k < NUM_STACKS - 1; k++) send_item(FIELD_W'(k * 4369), 16'h0001);
    send_item(16'hFF00, 16'h0002);
    wait_all_placed();

    for (int p = 0; p < 9; p++) begin
      cap = (phase_cap[p] < 0) ? int'($urandom_range(65535)) : phase_cap[p];
      write_capacity(FIELD_W'(cap));
      if (p == 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      for (int n = 0; n < phase_len[p]; n++)
        send_item(FIELD_W'($urandom()), pick_weight(cap));
      idle_pct  = 11;
      stall_pct = 11;
      wait_all_placed();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("first_fit_bin_allocator_unit verification clean");
    end else begin
      $display("first_fit_bin_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
